@@ rtl/utf8d_pkg.sv @@
// utf8d_pkg: types, constants and helper functions of the utf-8 codepoint decoder
// depends on nothing; used by every other file of the decoder
`default_nettype none

package utf8d_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned Q_DEPTH = 3;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // byte classes
    localparam logic [2:0] KIND_ASCII = 3'd0;
    localparam logic [2:0] KIND_LEAD1 = 3'd1;
    localparam logic [2:0] KIND_LEAD2 = 3'd2;
    localparam logic [2:0] KIND_LEAD3 = 3'd3;
    localparam logic [2:0] KIND_STRAY = 3'd4;

    // private-use ranges
    localparam logic [CP_W-1:0] PUA_BMP_LO = 21'h00E000;
    localparam logic [CP_W-1:0] PUA_BMP_HI = 21'h00F8FF;
    localparam logic [CP_W-1:0] PUA_A_LO   = 21'h0F0000;
    localparam logic [CP_W-1:0] PUA_A_HI   = 21'h0FFFFD;
    localparam logic [CP_W-1:0] PUA_B_LO   = 21'h100000;
    localparam logic [CP_W-1:0] PUA_B_HI   = 21'h10FFFD;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] f0;
        logic [7:0] f1;
        logic [1:0] count;
        logic       open;
    } state_t;

    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        logic            private_use;
        logic            run_end;
    } result_t;

    typedef struct packed {
        result_t r0;
        result_t r1;
        logic    v0;
        logic    v1;
        state_t  next;
    } step_t;

    typedef struct packed {
        result_t r0;
        result_t r1;
        logic    v0;
        logic    v1;
    } push_t;

    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] kind;
        unique casez (b)
            8'b0???????: kind = KIND_ASCII;
            8'b110?????: kind = KIND_LEAD1;
            8'b1110????: kind = KIND_LEAD2;
            8'b11110???: kind = KIND_LEAD3;
            default:     kind = KIND_STRAY;
        endcase
        return kind;
    endfunction

    // followers a lead asks for, 0 for anything else
    function automatic logic [1:0] followers(input logic [2:0] kind);
        logic [1:0] k;
        unique case (kind)
            KIND_LEAD1: k = 2'd1;
            KIND_LEAD2: k = 2'd2;
            KIND_LEAD3: k = 2'd3;
            default:    k = 2'd0;
        endcase
        return k;
    endfunction

    // lead, middle followers and the closing follower into one codepoint
    function automatic logic [CP_W-1:0] decode(input logic [7:0] lead,
                                               input logic [7:0] m1,
                                               input logic [7:0] m2,
                                               input logic [7:0] fin,
                                               input logic [1:0] k);
        logic [CP_W-1:0] cp;
        unique case (k)
            2'd1:    cp = {10'd0, lead[4:0], fin[5:0]};
            2'd2:    cp = {5'd0, lead[3:0], m1[5:0], fin[5:0]};
            default: cp = {lead[2:0], m1[5:0], m2[5:0], fin[5:0]};
        endcase
        return cp;
    endfunction

    function automatic logic is_private_use(input logic [CP_W-1:0] cp);
        return (cp >= PUA_BMP_LO && cp <= PUA_BMP_HI) ||
               (cp >= PUA_A_LO && cp <= PUA_A_HI) ||
               (cp >= PUA_B_LO && cp <= PUA_B_HI);
    endfunction

endpackage

`default_nettype wire

@@ rtl/utf8d_if.sv @@
// utf8d_if: valid/ready channels of the decoder, byte side and codepoint side
// depends on utf8d_pkg
`default_nettype none

interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_of_text;

    modport source (output valid, output byte_value, output last_of_text, input ready);
    modport sink (input valid, input byte_value, input last_of_text, output ready);
endinterface

interface utf8d_cp_if;
    logic                        valid;
    logic                        ready;
    logic [utf8d_pkg::CP_W-1:0]  codepoint;
    logic                        private_use;
    logic                        run_end;

    modport source (output valid, output codepoint, output private_use, output run_end,
                    input ready);
    modport sink (input valid, input codepoint, input private_use, input run_end,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/utf8d_step.sv @@
// utf8d_step: decode of one byte against the held sequence state
// yields up to two codepoints and the next state; depends on utf8d_pkg
`default_nettype none

module utf8d_step (
    input  utf8d_pkg::state_t st,
    input  logic [7:0]        byte_value,
    input  logic              last_of_text,
    output utf8d_pkg::step_t  res
);

    logic [2:0]                 kind_b;
    logic [2:0]                 kind_l;
    logic [2:0]                 kind_x;
    logic [1:0]                 k_l;
    logic                       complete;
    logic                       b_ascii;
    logic [utf8d_pkg::CP_W-1:0] seq_cp;
    logic [utf8d_pkg::CP_W-1:0] pair_cp;
    logic [utf8d_pkg::CP_W-1:0] cp0;
    logic [utf8d_pkg::CP_W-1:0] cp1;
    logic                       v0;
    logic                       v1;
    utf8d_pkg::state_t          nxt;

    always_comb
    begin
        kind_b   = utf8d_pkg::classify(byte_value);
        kind_l   = utf8d_pkg::classify(st.lead);
        kind_x   = utf8d_pkg::classify(st.f0);
        k_l      = utf8d_pkg::followers(kind_l);
        complete = st.open && ((st.count + 2'd1) == k_l);
        b_ascii  = (kind_b == utf8d_pkg::KIND_ASCII);
        seq_cp   = utf8d_pkg::decode(st.lead, st.f0, st.f1, byte_value, k_l);
        pair_cp  = utf8d_pkg::decode(st.f0, 8'h00, 8'h00, byte_value, 2'd1);
        cp0      = '0;
        cp1      = '0;
        v0       = 1'b0;
        v1       = 1'b0;
        nxt      = st;

        if (last_of_text)
        begin
            nxt = '0;
            if (complete)
            begin
                cp0 = seq_cp;
                v0  = 1'b1;
            end
            else if (st.open && st.count == 2'd1)
            begin
                // lead cut short: rescan the held follower and this byte
                if (kind_x == utf8d_pkg::KIND_ASCII)
                begin
                    cp0 = {13'd0, st.f0};
                    v0  = 1'b1;
                    cp1 = {13'd0, byte_value};
                    v1  = b_ascii;
                end
                else if (kind_x == utf8d_pkg::KIND_LEAD1)
                begin
                    cp0 = pair_cp;
                    v0  = 1'b1;
                end
                else
                begin
                    cp0 = {13'd0, byte_value};
                    v0  = b_ascii;
                end
            end
            else
            begin
                cp0 = {13'd0, byte_value};
                v0  = b_ascii;
            end
        end
        else if (st.open)
        begin
            if (complete)
            begin
                cp0 = seq_cp;
                v0  = 1'b1;
                nxt = '0;
            end
            else
            begin
                if (st.count == 2'd0)
                    nxt.f0 = byte_value;
                else
                    nxt.f1 = byte_value;
                nxt.count = st.count + 2'd1;
            end
        end
        else if (b_ascii)
        begin
            cp0 = {13'd0, byte_value};
            v0  = 1'b1;
        end
        else if (kind_b != utf8d_pkg::KIND_STRAY)
        begin
            nxt.lead  = byte_value;
            nxt.f0    = 8'h00;
            nxt.f1    = 8'h00;
            nxt.count = 2'd0;
            nxt.open  = 1'b1;
        end

        res.r0.codepoint   = cp0;
        res.r0.private_use = utf8d_pkg::is_private_use(cp0);
        res.r0.run_end     = !v1;
        res.r1.codepoint   = cp1;
        res.r1.private_use = utf8d_pkg::is_private_use(cp1);
        res.r1.run_end     = 1'b1;
        res.v0             = v0;
        res.v1             = v1;
        res.next           = nxt;
    end

endmodule

`default_nettype wire

@@ rtl/utf8d_queue.sv @@
// utf8d_queue: three-slot shifting result queue, up to two words pushed per cycle
// slot 0 drives the output port; depends on utf8d_pkg
`default_nettype none

module utf8d_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  utf8d_pkg::push_t      push,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output utf8d_pkg::result_t    out_word
);

    logic [utf8d_pkg::Q_CNT_W-1:0] count_reg;
    logic [utf8d_pkg::Q_CNT_W-1:0] count_next;
    logic [utf8d_pkg::Q_CNT_W-1:0] count_kept;
    utf8d_pkg::result_t            slot_reg  [utf8d_pkg::Q_DEPTH];
    utf8d_pkg::result_t            slot_next [utf8d_pkg::Q_DEPTH];
    logic                          pop;

    assign out_valid = (count_reg != '0);
    assign out_word  = slot_reg[0];
    assign pop       = out_valid && out_ready;
    // two free slots before any pop, so an item is never refused for a waiting word
    assign room      = (count_reg <= utf8d_pkg::Q_CNT_W'(utf8d_pkg::Q_DEPTH - 2));

    always_comb
    begin
        count_kept = count_reg - utf8d_pkg::Q_CNT_W'(pop);
        for (int i = 0; i < utf8d_pkg::Q_DEPTH; i++)
        begin
            if (pop && i < utf8d_pkg::Q_DEPTH - 1)
                slot_next[i] = slot_reg[i + 1];
            else
                slot_next[i] = slot_reg[i];
            if (push.v0 && count_kept == utf8d_pkg::Q_CNT_W'(i))
                slot_next[i] = push.r0;
            if (push.v1 && (count_kept + utf8d_pkg::Q_CNT_W'(1)) == utf8d_pkg::Q_CNT_W'(i))
                slot_next[i] = push.r1;
        end
        count_next = count_kept + utf8d_pkg::Q_CNT_W'(push.v0)
                                + utf8d_pkg::Q_CNT_W'(push.v1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < utf8d_pkg::Q_DEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

endmodule

`default_nettype wire

@@ rtl/utf8_codepoint_decoder.sv @@
// utf8_codepoint_decoder: lenient utf-8 byte stream to 21-bit codepoints
// depends on utf8d_pkg, utf8d_if, utf8d_step, utf8d_queue
//
//   channel      side   word fields                              handshake
//   text         sink   byte_value[7:0], last_of_text            valid/ready
//   codepoints   source codepoint[20:0], private_use, run_end    valid/ready
//
// one byte is taken per cycle while text.ready is high; each byte is decoded in the
// cycle it is accepted and its 0, 1 or 2 codepoints are written into a three-word
// result queue at the accepting edge, so with an empty queue the first of them is
// offered in the cycle after the byte; the queue drains one word per cycle while
// codepoints.ready is high; text.ready drops only while two or more words wait
// rst_n clears the held sequence and empties the queue; queue payload has no reset
`default_nettype none

module utf8_codepoint_decoder (
    input  logic              clk,
    input  logic              rst_n,
    utf8d_byte_if.sink        text,
    utf8d_cp_if.source        codepoints
);

    utf8d_pkg::state_t  state_reg;
    utf8d_pkg::state_t  state_next;
    utf8d_pkg::step_t   step;
    utf8d_pkg::push_t   push;
    utf8d_pkg::result_t head;
    logic               room;
    logic               accept;

    // byte handshake
    assign text.ready = room;
    assign accept     = text.valid && room;

    // decode of the incoming byte against the held lead and followers
    utf8d_step u_step (
        .st           (state_reg),
        .byte_value   (text.byte_value),
        .last_of_text (text.last_of_text),
        .res          (step)
    );

    // sequence state advances only on an accepted byte
    assign state_next = accept ? step.next : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    // results of the accepted byte go into the queue
    always_comb
    begin
        push.r0 = step.r0;
        push.r1 = step.r1;
        push.v0 = accept && step.v0;
        push.v1 = accept && step.v1;
    end

    utf8d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (codepoints.valid),
        .out_ready (codepoints.ready),
        .out_word  (head)
    );

    // output word from the queue head
    assign codepoints.codepoint   = head.codepoint;
    assign codepoints.private_use = head.private_use;
    assign codepoints.run_end     = head.run_end;

endmodule

`default_nettype wire

@@ rtl/utf8d_checker.sv @@
// utf8d_checker: port-level assertions for utf8_codepoint_decoder, with its bind
// depends on utf8d_pkg
`default_nettype none

module utf8d_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [utf8d_pkg::CP_W-1:0] codepoint,
    input  logic                       private_use,
    input  logic                       run_end
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(codepoint)
            && $stable(private_use) && $stable(run_end))
        else $error("stalled codepoint word changed");

    // private-use flag matches the codepoint
    a_pua: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> private_use == utf8d_pkg::is_private_use(codepoint))
        else $error("private_use flag wrong");

    // byte side only backs up behind waiting words
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("byte side stalled with no result waiting");

    // a word without run_end has its partner queued behind it
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_end |=> out_valid)
        else $error("second codepoint of a byte missing");

    // an offered byte stays up until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("offered byte withdrawn before it was taken");

endmodule

bind utf8_codepoint_decoder utf8d_checker u_utf8d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (text.valid),
    .in_ready    (text.ready),
    .out_valid   (codepoints.valid),
    .out_ready   (codepoints.ready),
    .codepoint   (codepoints.codepoint),
    .private_use (codepoints.private_use),
    .run_end     (codepoints.run_end)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for utf8_codepoint_decoder, driven from a word backlog
// depends on utf8d_pkg, utf8d_if and the decoder rtl

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // one word of the text channel as the bench queues it
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_of_text;
    } text_word_t;

    // ways the codepoint receiver can behave for a stretch of cycles
    typedef enum logic [1:0] {
        SINK_FREE,      // always ready
        SINK_COIN,      // ready half of the time
        SINK_SPARSE,    // ready about one cycle in four
        SINK_PATTERN    // ready follows a rotating bit pattern
    } sink_mode_t;

    localparam int unsigned PART_A_WORDS  = 700;
    localparam int unsigned TOTAL_WORDS   = 1250;
    localparam int unsigned HOLD_AFTER    = 200;   // codepoints seen before the long stall
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned DRAIN_CYCLES  = 12;

    logic clk = 1'b0;
    logic rst_n;

    utf8d_byte_if text_ch ();
    utf8d_cp_if   cp_ch ();

    utf8_codepoint_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text_ch),
        .codepoints (cp_ch)
    );

    always #10 clk = ~clk;

    // words not yet offered, and codepoints predicted but not yet seen
    text_word_t          text_backlog[$];
    utf8d_pkg::result_t  pending_codepoints[$];
    logic [7:0]          seg_bytes[$];

    int unsigned mismatches   = 0;
    int unsigned cps_seen     = 0;
    int unsigned words_queued = 0;

    // bench copy of the decoder's held sequence
    logic [7:0] held_lead      = 8'h00;
    logic [7:0] held_follow[2] = '{8'h00, 8'h00};
    logic [1:0] held_cnt       = 2'd0;
    logic       seq_open       = 1'b0;

    // sender and receiver bookkeeping
    int unsigned words_offered = 0;
    int unsigned words_taken   = 0;
    int unsigned burst_left    = 0;
    int unsigned gap_left      = 0;
    int unsigned hold_left     = 0;
    logic        held_once     = 1'b0;
    int unsigned mode_left     = 0;
    sink_mode_t  sink_mode     = SINK_FREE;
    logic [7:0]  sink_pat      = 8'b1011_0010;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // followers a byte asks for: 0 for ascii, -1 for a byte that cannot lead
    function automatic int lead_followers(input logic [7:0] b);
        if (!b[7])
            return 0;
        if (b[7:5] == 3'b110)
            return 1;
        if (b[7:4] == 4'b1110)
            return 2;
        if (b[7:3] == 5'b11110)
            return 3;
        return -1;
    endfunction

    // lead in seq[0], k followers after it; only low six bits of a follower count
    function automatic logic [20:0] join_bits(input logic [3:0][7:0] seq, input int k);
        logic [31:0] acc;
        int          i;
        case (k)
            1:       acc = {27'd0, seq[0][4:0]};
            2:       acc = {28'd0, seq[0][3:0]};
            default: acc = {29'd0, seq[0][2:0]};
        endcase
        for (i = 1; i <= k; i++)
            acc = (acc << 6) | {26'd0, seq[i][5:0]};
        return acc[20:0];
    endfunction

    function automatic logic in_private_range(input logic [20:0] cp);
        return (cp >= 21'h00E000 && cp <= 21'h00F8FF) ||
               (cp >= 21'h0F0000 && cp <= 21'h0FFFFD) ||
               (cp >= 21'h100000 && cp <= 21'h10FFFD);
    endfunction

    task automatic clear_held();
        held_lead      = 8'h00;
        held_follow[0] = 8'h00;
        held_follow[1] = 8'h00;
        held_cnt       = 2'd0;
        seq_open       = 1'b0;
    endtask

    // runs one accepted text word through the bench copy and queues its codepoints
    task automatic decode_byte(input text_word_t w);
        logic [3:0][7:0]    scan;
        logic [3:0][7:0]    seq;
        logic [20:0]        found[$];
        utf8d_pkg::result_t r;
        int                 n, pos, k, have, i;
        scan = '0;
        seq  = '0;
        if (w.last_of_text)
        begin
            // end of text: held bytes plus this one are scanned as a short text,
            // a cut-short lead is dropped and the scan goes on after it
            n = 0;
            if (seq_open)
            begin
                scan[n] = held_lead;
                n++;
                for (i = 0; i < int'(held_cnt) && i < 2; i++)
                begin
                    scan[n] = held_follow[i];
                    n++;
                end
            end
            scan[n] = w.byte_value;
            n++;
            pos = 0;
            while (pos < n)
            begin
                k = lead_followers(scan[pos]);
                if (k == 0)
                begin
                    if (found.size() < 2)
                        found.insert(found.size(), {13'd0, scan[pos]});
                    pos++;
                end
                else if (k > 0 && pos + k < n)
                begin
                    for (i = 0; i <= k; i++)
                        seq[i] = scan[pos + i];
                    if (found.size() < 2)
                        found.insert(found.size(), join_bits(seq, k));
                    pos += k + 1;
                end
                else
                begin
                    pos++;
                end
            end
            clear_held();
        end
        else if (seq_open)
        begin
            // any byte counts as a follower, continuation or not
            k    = lead_followers(held_lead);
            have = int'(held_cnt);
            if (k < 1 || have > 2)
            begin
                clear_held();
            end
            else if (have + 1 >= k)
            begin
                seq[0] = held_lead;
                for (i = 0; i < have; i++)
                    seq[1 + i] = held_follow[i];
                seq[1 + have] = w.byte_value;
                found.insert(found.size(), join_bits(seq, k));
                clear_held();
            end
            else
            begin
                held_follow[have] = w.byte_value;
                held_cnt          = 2'(have + 1);
            end
        end
        else
        begin
            k = lead_followers(w.byte_value);
            if (k == 0)
            begin
                found.insert(found.size(), {13'd0, w.byte_value});
            end
            else if (k > 0)
            begin
                held_lead      = w.byte_value;
                held_follow[0] = 8'h00;
                held_follow[1] = 8'h00;
                held_cnt       = 2'd0;
                seq_open       = 1'b1;
            end
            // stray bytes fall through with no codepoint
        end
        for (i = 0; i < found.size(); i++)
        begin
            r.codepoint   = found[i];
            r.private_use = in_private_range(found[i]);
            r.run_end     = (i == found.size() - 1);
            pending_codepoints.insert(pending_codepoints.size(), r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [20:0] want,
                                   input logic [20:0] got);
        mismatches++;
        $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    task automatic queue_word(input logic [7:0] b, input logic last);
        text_word_t w;
        w.byte_value   = b;
        w.last_of_text = last;
        text_backlog.insert(text_backlog.size(), w);
        words_queued++;
    endtask

    // encodes cp as a lead with k followers; sloppy followers get random top bits
    task automatic add_sequence(input int k, input logic [20:0] cp, input logic sloppy);
        int         i;
        logic [1:0] top;
        case (k)
            0:       seg_bytes.insert(seg_bytes.size(), {1'b0, cp[6:0]});
            1:       seg_bytes.insert(seg_bytes.size(), {3'b110, cp[10:6]});
            2:       seg_bytes.insert(seg_bytes.size(), {4'b1110, cp[15:12]});
            default: seg_bytes.insert(seg_bytes.size(), {5'b11110, cp[20:18]});
        endcase
        for (i = k - 1; i >= 0; i--)
        begin
            top = sloppy ? 2'($urandom_range(0, 3)) : 2'b10;
            seg_bytes.insert(seg_bytes.size(), {top, cp[6*i +: 6]});
        end
    endtask

    // codepoints on and around the private-use range edges
    function automatic logic [20:0] edge_codepoint(input int idx);
        case (idx)
            0:       return 21'h00DFFF;
            1:       return 21'h00E000;
            2:       return 21'h00F8FF;
            3:       return 21'h00F900;
            4:       return 21'h0EFFFF;
            5:       return 21'h0F0000;
            6:       return 21'h0FFFFD;
            7:       return 21'h0FFFFE;
            8:       return 21'h0FFFFF;
            9:       return 21'h100000;
            10:      return 21'h10FFFD;
            11:      return 21'h10FFFE;
            default: return 21'h1FFFFF;
        endcase
    endfunction

    // one text: mostly well-formed characters, some noise, sometimes a cut-short tail
    task automatic queue_random_text();
        int          chars, c, sel, k, i;
        logic [20:0] cp;
        seg_bytes.delete();
        chars = $urandom_range(1, 12);
        for (c = 0; c < chars; c++)
        begin
            sel = $urandom_range(0, 99);
            cp  = 21'($urandom);
            if (sel < 30)
            begin
                add_sequence(0, cp, 1'b0);
            end
            else if (sel < 70)
            begin
                add_sequence($urandom_range(1, 3), cp, 1'b0);
            end
            else if (sel < 80)
            begin
                cp = edge_codepoint($urandom_range(0, 12));
                k  = (cp < 21'h010000 && $urandom_range(0, 3) != 0) ? 2 : 3;
                add_sequence(k, cp, 1'b0);
            end
            else if (sel < 87)
            begin
                add_sequence($urandom_range(1, 3), cp, 1'b1);
            end
            else if (sel < 94)
            begin
                // byte that cannot start a sequence
                if ($urandom_range(0, 1) == 1)
                    seg_bytes.insert(seg_bytes.size(), 8'($urandom_range(8'h80, 8'hBF)));
                else
                    seg_bytes.insert(seg_bytes.size(), 8'($urandom_range(8'hF8, 8'hFF)));
            end
            else
            begin
                seg_bytes.insert(seg_bytes.size(), 8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            // lead with too few followers, or the whole sequence popped again, then a random final byte
            k = $urandom_range(1, 3);
            add_sequence(k, 21'($urandom), 1'b1);
            for (i = 0; i <= k - int'($urandom_range(0, k - 1)); i++)
                void'(seg_bytes.pop_back());
            seg_bytes.insert(seg_bytes.size(), 8'($urandom_range(0, 255)));
        end
        for (i = 0; i < seg_bytes.size(); i++)
            queue_word(seg_bytes[i], i == seg_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (text_backlog.size() != 0 || text_ch.valid || pending_codepoints.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // text sender: bursts of words with random gaps, changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : sender
        text_word_t w;
        if (!rst_n)
        begin
            text_ch.valid        <= 1'b0;
            text_ch.byte_value   <= 8'h00;
            text_ch.last_of_text <= 1'b0;
        end
        else if (words_taken == words_offered)
        begin
            // nothing on the bus, or the word on it was taken at the last edge
            if (gap_left > 0)
            begin
                gap_left--;
                text_ch.valid <= 1'b0;
            end
            else if (text_backlog.size() > 0)
            begin
                w = text_backlog.pop_front();
                text_ch.valid        <= 1'b1;
                text_ch.byte_value   <= w.byte_value;
                text_ch.last_of_text <= w.last_of_text;
                words_offered++;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // next burst; a third of the bursts follow with no gap at all
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                text_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // codepoint receiver: own stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            cp_ch.ready <= 1'b0;
        end
        else
        begin
            // once enough codepoints are through, hold off long enough that the
            // result queue fills and the text side gets back-pressured
            if (!held_once && cps_seen >= HOLD_AFTER)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    sink_mode = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                sink_pat = {sink_pat[6:0], sink_pat[7]};
                case (sink_mode)
                    SINK_FREE:   cp_ch.ready <= 1'b1;
                    SINK_COIN:   cp_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: cp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:     cp_ch.ready <= sink_pat[0];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks codepoint words, then predicts from accepted text words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        utf8d_pkg::result_t want;
        text_word_t         w;
        if (rst_n)
        begin
            if (cp_ch.valid && cp_ch.ready)
            begin
                cps_seen++;
                if (pending_codepoints.size() == 0)
                begin
                    report_mismatch("codepoint word with nothing pending", 21'd0,
                                    cp_ch.codepoint);
                end
                else
                begin
                    want = pending_codepoints.pop_front();
                    if (cp_ch.codepoint !== want.codepoint)
                        report_mismatch("codepoint", want.codepoint, cp_ch.codepoint);
                    if (cp_ch.private_use !== want.private_use)
                        report_mismatch("private_use", 21'(want.private_use),
                                        21'(cp_ch.private_use));
                    if (cp_ch.run_end !== want.run_end)
                        report_mismatch("run_end", 21'(want.run_end), 21'(cp_ch.run_end));
                end
            end
            if (text_ch.valid && text_ch.ready)
            begin
                w.byte_value   = text_ch.byte_value;
                w.last_of_text = text_ch.last_of_text;
                decode_byte(w);
                words_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;

        // directed: the lowest ascii value and stray bytes
        queue_word(8'h00, 1'b0);
        queue_word(8'h80, 1'b0);
        queue_word(8'hF8, 1'b0);
        // two, three and four byte forms, private-use edges, the largest value
        queue_word(8'hC3, 1'b0);
        queue_word(8'hA9, 1'b0);
        queue_word(8'hEE, 1'b0);
        queue_word(8'h80, 1'b0);
        queue_word(8'h80, 1'b0);
        queue_word(8'hF4, 1'b0);
        queue_word(8'h8F, 1'b0);
        queue_word(8'hBF, 1'b0);
        queue_word(8'hBD, 1'b0);
        queue_word(8'hF7, 1'b0);
        queue_word(8'hBF, 1'b0);
        queue_word(8'hBF, 1'b0);
        queue_word(8'hBF, 1'b0);
        // follower that is not a continuation byte, overlong result
        queue_word(8'hC1, 1'b0);
        queue_word(8'h41, 1'b0);
        // text ends inside a four byte form: lead dropped, two ascii words out
        queue_word(8'hF0, 1'b0);
        queue_word(8'h41, 1'b0);
        queue_word(8'h42, 1'b1);
        // cut-short lead dropped, the rest rescanned as a two byte form
        queue_word(8'hF1, 1'b0);
        queue_word(8'hC3, 1'b0);
        queue_word(8'hA9, 1'b1);
        // lone lead and a stray byte at the end of a text: nothing out
        queue_word(8'hC3, 1'b1);
        queue_word(8'hFF, 1'b1);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_drained();
        while (words_queued < PART_A_WORDS)
            queue_random_text();
        // sender stops until every pending codepoint is out
        wait_drained();
        while (words_queued < TOTAL_WORDS)
            queue_random_text();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("timeout with %0d codepoints pending", pending_codepoints.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
